// ----- sv/msed_pkg.sv -----
// shared types, constants and entity name table for the markup strip entity decoder
package msed_pkg;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned MAX_RESULTS = 10;
	localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int unsigned NUM_NAMES   = 8;

	localparam logic [6:0] NUM_MIN = 7'd32;
	localparam logic [6:0] NUM_MAX = 7'd126;
	localparam logic [6:0] NUM_SAT = 7'd127;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INPUT,
		ST_RUN
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_INPUT,
		OP_REPLAY,
		OP_FLUSH,
		OP_MARK
	} op_t;

	typedef enum logic [1:0] {
		NP_PRE,
		NP_SIGN,
		NP_DIGIT,
		NP_DONE
	} num_phase_t;

	typedef struct packed {
		op_t  op;
		logic en;
	} cmd_t;

	typedef struct packed {
		logic stall;
		logic replay_busy;
		logic replay_next;
		logic amp;
		logic eot;
	} status_t;

	// name text, first character in the top byte
	function automatic logic [31:0] name_text(input logic [2:0] e);
		logic [31:0] t;
		t = '0;
		case (e)
			3'd0: t = {"amp", 8'h00};
			3'd1: t = {"lt", 16'h0000};
			3'd2: t = {"gt", 16'h0000};
			3'd3: t = "quot";
			3'd4: t = "apos";
			3'd5: t = {"#39", 8'h00};
			3'd6: t = "nbsp";
			3'd7: t = "#160";
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] name_len(input logic [2:0] e);
		logic [2:0] l;
		l = '0;
		case (e)
			3'd0: l = 3'd3;
			3'd1: l = 3'd2;
			3'd2: l = 3'd2;
			3'd3: l = 3'd4;
			3'd4: l = 3'd4;
			3'd5: l = 3'd3;
			3'd6: l = 3'd4;
			3'd7: l = 3'd4;
			default: l = '0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] name_val(input logic [2:0] e);
		logic [7:0] v;
		v = '0;
		case (e)
			3'd0: v = 8'h26;
			3'd1: v = 8'h3C;
			3'd2: v = 8'h3E;
			3'd3: v = 8'h22;
			3'd4: v = 8'h27;
			3'd5: v = 8'h27;
			3'd6: v = 8'h20;
			3'd7: v = 8'h20;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/msed_if.sv -----
// channel interfaces: text bytes in, decoded results out, configuration writes
interface msed_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_text;

	modport source (output valid, output in_char, output end_of_text, input ready);
	modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

interface msed_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       final_res;

	modport source (output valid, output out_char, output has_char, output final_res,
		input ready);
	modport sink (input valid, input out_char, input has_char, input final_res,
		output ready);
endinterface

interface msed_cfg_if;
	logic valid;
	logic ready;
	logic strip_markup;

	modport source (output valid, output strip_markup, input ready);
	modport sink (input valid, input strip_markup, output ready);
endinterface

// ----- sv/msed_ctrl.sv -----
// controller state machine: sequences load, decode, replay, flush and end marker steps
module msed_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msed_pkg::status_t status,
	output msed_pkg::cmd_t    cmd
);
	import msed_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = OP_LOAD;
				cmd.en   = in_valid;
				if (in_valid) begin
					state_nx = ST_INPUT;
				end
			end
			ST_INPUT: begin
				cmd.op = OP_INPUT;
				cmd.en = !status.stall;
				if (!status.stall) begin
					state_nx = (status.replay_next || status.eot) ? ST_RUN : ST_IDLE;
				end
			end
			ST_RUN: begin
				cmd.en = !status.stall;
				if (status.replay_busy) begin
					cmd.op = OP_REPLAY;
					if (!status.stall) begin
						state_nx = (status.replay_next || status.eot) ? ST_RUN : ST_IDLE;
					end
				end else if (status.amp) begin
					// end of text with an open entity: emit its '&' and replay the rest
					cmd.op = OP_FLUSH;
				end else begin
					cmd.op = OP_MARK;
					if (!status.stall) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/msed_dp.sv -----
// datapath: tag filter, held byte ring, entity name recognizer and output register
module msed_dp #(
	parameter int unsigned LOOKAHEAD = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msed_pkg::cmd_t    cmd,
	output msed_pkg::status_t status,
	input  logic [7:0]        in_char,
	input  logic              end_of_text,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        out_char,
	output logic              has_char,
	output logic              final_res
);
	import msed_pkg::*;

	localparam int unsigned PW = $clog2(LOOKAHEAD);
	localparam int unsigned CW = $clog2(LOOKAHEAD + 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(LOOKAHEAD - 1)) ? '0 : p + 1'b1;
	endfunction

	// control state
	logic             strip_q;
	logic             inside_q;
	logic             amp_q;
	logic             eot_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    rem_q;
	logic [PW-1:0]    base_q;
	logic [PW-1:0]    rd_q;
	logic [RES_W-1:0] res_cnt_q;
	logic             out_valid_q;

	// payload state
	logic [7:0]       byte_q;
	logic [7:0]       pend_q [LOOKAHEAD];
	logic [NUM_NAMES-1:0] alive_q;
	logic             hash_q;
	num_phase_t       ph_q;
	logic             neg_q;
	logic             dig_q;
	logic [6:0]       val_q;
	logic [7:0]       out_char_q;
	logic             has_char_q;
	logic             final_q;

	logic [7:0]       cur_c;

	// recognizer next values
	logic [NUM_NAMES-1:0] alive_nx;
	logic [NUM_NAMES-1:0] hit;
	logic             hash_nx;
	num_phase_t       ph_nx;
	logic             neg_nx;
	logic             dig_nx;
	logic [6:0]       val_nx;
	logic             res_ok;
	logic [7:0]       res_val;

	// step next values
	logic             inside_nx;
	logic             amp_nx;
	logic [CW-1:0]    cnt_nx;
	logic [CW-1:0]    rem_nx;
	logic [PW-1:0]    base_nx;
	logic [PW-1:0]    rd_nx;
	logic             wr_en;
	logic [PW-1:0]    waddr;
	logic             rec_upd;
	logic             emit_want;
	logic             emit_ok;
	logic [7:0]       emit_chr;
	logic             emit_has;
	logic             emit_fin;

	assign cur_c = (cmd.op == OP_REPLAY) ? pend_q[rd_q] : byte_q;

	// name and numeric entity recognizer, one byte of the entity text per step
	always_comb begin
		logic [31:0] nm;
		logic [2:0]  ln;
		logic [7:0]  ch;
		logic        is_dig;
		logic        is_ws;
		logic [3:0]  dval;
		logic [10:0] vmul;
		logic [7:0]  tval;
		nm      = '0;
		ln      = '0;
		ch      = '0;
		tval    = '0;
		is_dig  = (cur_c >= CH_ZERO) && (cur_c <= CH_NINE);
		is_ws   = (cur_c == CH_SPACE) || ((cur_c >= CH_TAB) && (cur_c <= CH_CR));
		dval    = 4'(cur_c - CH_ZERO);
		vmul    = (11'(val_q) << 3) + (11'(val_q) << 1) + 11'(dval);
		for (int e = 0; e < NUM_NAMES; e++) begin
			nm = name_text(3'(e));
			ln = name_len(3'(e));
			ch = nm[8 * (3 - int'(cnt_q[1:0])) +: 8];
			alive_nx[e] = ((cnt_q == '0) || alive_q[e]) && (cnt_q < CW'(ln)) && (ch == cur_c);
			hit[e] = alive_q[e] && (cnt_q == CW'(ln));
			if (hit[e]) begin
				tval = tval | name_val(3'(e));
			end
		end

		hash_nx = hash_q;
		ph_nx   = ph_q;
		neg_nx  = neg_q;
		dig_nx  = dig_q;
		val_nx  = val_q;
		if (cnt_q == '0) begin
			hash_nx = (cur_c == CH_HASH);
			ph_nx   = NP_PRE;
			neg_nx  = 1'b0;
			dig_nx  = 1'b0;
			val_nx  = '0;
		end else begin
			case (ph_q)
				NP_PRE: begin
					if (is_ws) begin
						ph_nx = NP_PRE;
					end else if ((cur_c == CH_PLUS) || (cur_c == CH_MINUS)) begin
						neg_nx = (cur_c == CH_MINUS);
						ph_nx  = NP_SIGN;
					end else if (is_dig) begin
						ph_nx  = NP_DIGIT;
						dig_nx = 1'b1;
						val_nx = (vmul > 11'(NUM_SAT)) ? NUM_SAT : vmul[6:0];
					end else begin
						ph_nx = NP_DONE;
					end
				end
				NP_SIGN, NP_DIGIT: begin
					if (is_dig) begin
						ph_nx  = NP_DIGIT;
						dig_nx = 1'b1;
						val_nx = (vmul > 11'(NUM_SAT)) ? NUM_SAT : vmul[6:0];
					end else begin
						ph_nx = NP_DONE;
					end
				end
				NP_DONE: begin
					ph_nx = NP_DONE;
				end
				default: begin
					ph_nx = NP_DONE;
				end
			endcase
		end

		// a named entity wins over the numeric reading of the same text
		res_ok  = (|hit) || ((cnt_q != '0) && hash_q && dig_q && !neg_q &&
			(val_q >= NUM_MIN) && (val_q <= NUM_MAX));
		res_val = (|hit) ? tval : {1'b0, val_q};
	end

	// one decode step
	always_comb begin
		logic          pass;
		logic          feed;
		logic          rep;
		logic          fail;
		logic [CW-1:0] cnt_inc;
		logic [CW:0]   wsum;
		inside_nx = inside_q;
		amp_nx    = amp_q;
		cnt_nx    = cnt_q;
		rem_nx    = rem_q;
		base_nx   = base_q;
		rd_nx     = rd_q;
		wr_en     = 1'b0;
		rec_upd   = 1'b0;
		emit_want = 1'b0;
		emit_chr  = cur_c;
		emit_has  = 1'b1;
		emit_fin  = 1'b0;
		pass      = 1'b1;
		fail      = 1'b0;
		rep       = (cmd.op == OP_REPLAY);
		cnt_inc   = cnt_q + 1'b1;
		wsum      = (CW + 1)'(base_q) + (CW + 1)'(cnt_q);
		if (wsum >= (CW + 1)'(LOOKAHEAD)) begin
			wsum = wsum - (CW + 1)'(LOOKAHEAD);
		end
		waddr = wsum[PW-1:0];

		if ((cmd.op == OP_INPUT) && strip_q) begin
			if (cur_c == CH_LT) begin
				inside_nx = 1'b1;
				pass      = 1'b0;
			end else if (cur_c == CH_GT) begin
				inside_nx = 1'b0;
				pass      = 1'b0;
			end else if (inside_q) begin
				pass = 1'b0;
			end
		end
		feed = rep || ((cmd.op == OP_INPUT) && pass);

		if (rep) begin
			rd_nx  = ptr_inc(rd_q);
			rem_nx = rem_q - 1'b1;
		end

		if (feed) begin
			if (!amp_q) begin
				if (cur_c == CH_AMP) begin
					amp_nx  = 1'b1;
					cnt_nx  = '0;
					// a replayed '&' opens a name on the bytes already held behind it
					base_nx = rep ? ptr_inc(rd_q) : '0;
				end else begin
					emit_want = 1'b1;
				end
			end else begin
				wr_en   = !rep;
				rec_upd = 1'b1;
				cnt_nx  = cnt_inc;
				if (cur_c == CH_SEMI) begin
					if (res_ok) begin
						emit_want = 1'b1;
						emit_chr  = res_val;
						amp_nx    = 1'b0;
						cnt_nx    = '0;
					end else begin
						fail = 1'b1;
					end
				end else if (cnt_inc == CW'(LOOKAHEAD)) begin
					fail = 1'b1;
				end
				if (fail) begin
					emit_want = 1'b1;
					emit_chr  = CH_AMP;
					amp_nx    = 1'b0;
					cnt_nx    = '0;
					rd_nx     = base_q;
					rem_nx    = rem_nx + cnt_inc;
				end
			end
		end

		case (cmd.op)
			OP_FLUSH: begin
				emit_want = 1'b1;
				emit_chr  = CH_AMP;
				amp_nx    = 1'b0;
				cnt_nx    = '0;
				rd_nx     = base_q;
				rem_nx    = cnt_q;
			end
			OP_MARK: begin
				emit_want = 1'b1;
				emit_chr  = '0;
				emit_has  = 1'b0;
				emit_fin  = 1'b1;
				inside_nx = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign emit_ok = emit_want && (res_cnt_q < RES_W'(MAX_RESULTS));

	assign status.stall       = emit_ok && out_valid_q && !out_ready;
	assign status.replay_busy = (rem_q != '0);
	assign status.replay_next = (rem_nx != '0);
	assign status.amp         = amp_q;
	assign status.eot         = eot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q     <= 1'b1;
			inside_q    <= 1'b0;
			amp_q       <= 1'b0;
			eot_q       <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			base_q      <= '0;
			rd_q        <= '0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				strip_q <= cfg_data;
			end
			if (cmd.en) begin
				inside_q <= inside_nx;
				amp_q    <= amp_nx;
				cnt_q    <= cnt_nx;
				rem_q    <= rem_nx;
				base_q   <= base_nx;
				rd_q     <= rd_nx;
				if (cmd.op == OP_LOAD) begin
					eot_q     <= end_of_text;
					res_cnt_q <= '0;
				end else if (emit_ok) begin
					res_cnt_q <= res_cnt_q + 1'b1;
				end
			end
			if (cmd.en && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en && (cmd.op == OP_LOAD)) begin
			byte_q <= in_char;
		end
		if (cmd.en && wr_en) begin
			pend_q[waddr] <= cur_c;
		end
		if (cmd.en && rec_upd) begin
			alive_q <= alive_nx;
			hash_q  <= hash_nx;
			ph_q    <= ph_nx;
			neg_q   <= neg_nx;
			dig_q   <= dig_nx;
			val_q   <= val_nx;
		end
		if (cmd.en && emit_ok) begin
			out_char_q <= emit_chr;
			has_char_q <= emit_has;
			final_q    <= emit_fin;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign has_char  = has_char_q;
	assign final_res = final_q;

endmodule

// ----- sv/markup_strip_entity_decoder.sv -----
// markup strip entity decoder top level: controller plus datapath
// a byte is taken in the idle state and decoded in the input state, which waits on a stall;
// its result is registered at the end of the decode step and shown from the next cycle on
// a failed entity adds one decode step per held byte replayed, and end of text adds one
// step per flushed '&' plus one for the end marker; the one-byte decode step sets the rate
// arst_n clears the controller, tag and entity state; strip_markup resets to 1
module markup_strip_entity_decoder #(
	parameter int unsigned LOOKAHEAD = 8
) (
	input logic         clk,
	input logic         arst_n,
	msed_char_if.sink   chars,
	msed_res_if.source  results,
	msed_cfg_if.sink    cfg
);
	import msed_pkg::*;

	cmd_t    cmd;
	status_t status;

	msed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.status   (status),
		.cmd      (cmd)
	);

	msed_dp #(
		.LOOKAHEAD (LOOKAHEAD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_char     (chars.in_char),
		.end_of_text (chars.end_of_text),
		.cfg_valid   (cfg.valid),
		.cfg_ready   (cfg.ready),
		.cfg_data    (cfg.strip_markup),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.out_char    (results.out_char),
		.has_char    (results.has_char),
		.final_res   (results.final_res)
	);

endmodule

// ----- sv/msed_checker.sv -----
// port level checks for the markup strip entity decoder, bound to the top level
module msed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       has_char,
	input logic       final_res
);

	// a byte is decoded after its request, in the input state, so no back to back requests
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the cycle after a request");

	// a result cannot appear in the cycle right after a request was taken
	a_result_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared without a decode step");

	// a bare end marker is always the final result and carries a zero byte
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> final_res && (out_char == 8'h00))
		else $error("malformed end marker");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) &&
			$stable(has_char) && $stable(final_res))
		else $error("stalled result changed");

endmodule

bind markup_strip_entity_decoder msed_checker u_msed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_char  (results.out_char),
	.has_char  (results.has_char),
	.final_res (results.final_res)
);
